FILE: rtl/assert_macros.svh
// assertion macros for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define RFR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

`define RFR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define RFR_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)

`define RFR_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

FILE: rtl/rfr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rfr_pkg;

  localparam int unsigned MaxFrameDefault = 20;
  localparam logic [7:0] TimeoutReset = 8'd11;

  localparam logic [1:0] OpByte = 2'd0;
  localparam logic [1:0] OpTick = 2'd1;
  localparam logic [1:0] OpArm  = 2'd2;

  localparam logic [2:0] StOk       = 3'd0;
  localparam logic [2:0] StError    = 3'd1;
  localparam logic [2:0] StUnknown  = 3'd2;
  localparam logic [2:0] StChecksum = 3'd3;
  localparam logic [2:0] StTimeout  = 3'd4;
  localparam logic [2:0] StOverflow = 3'd5;

  localparam logic [1:0] PhLead = 2'd0;
  localparam logic [1:0] PhNum  = 2'd1;
  localparam logic [1:0] PhDone = 2'd2;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChC     = 8'h43;

  localparam logic [31:0] AccLimit = 32'h8000_0000;
  localparam logic [31:0] PosMax   = 32'h7FFF_FFFF;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] value;
  } rsp_t;

  typedef struct packed {
    logic valid;
    rsp_t rsp;
  } step_res_t;

endpackage

`default_nettype wire

FILE: rtl/rfr_core.sv
`timescale 1ns / 1ps
`default_nettype none

module rfr_core
  import rfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MaxFrameDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  req_t       item,
  input  logic [7:0] timeout_ticks,
  output step_res_t  res,
  output logic       armed
);

  logic [4:0]  byte_count, byte_count_next;
  logic [7:0]  idle_ticks, idle_ticks_next;
  logic [7:0]  xor_sum, xor_sum_next;
  logic [7:0]  last_byte, last_byte_next;
  logic [7:0]  first_byte, first_byte_next;
  logic [1:0]  parse_phase, parse_phase_next;
  logic        negative, negative_next;
  logic [31:0] number_acc, number_acc_next;
  logic        armed_next;

  logic        clear;
  logic [7:0]  idle_inc;
  logic        p_digit, p_space, p_sign;
  logic [35:0] mul10;
  logic [31:0] acc_sat;
  logic [31:0] final_value;
  logic        is_term;

  // parser runs one byte late, on the previous byte
  assign p_digit = (last_byte >= ChZero) && (last_byte <= ChNine);
  assign p_space = (last_byte == ChSpace) || ((last_byte >= ChTab) && (last_byte <= ChCr));
  assign p_sign  = (last_byte == ChMinus) || (last_byte == ChPlus);
  assign mul10   = {1'b0, number_acc, 3'b000} + {3'b000, number_acc, 1'b0}
                 + {32'd0, 4'(last_byte - ChZero)};
  assign acc_sat = (mul10 > {4'd0, AccLimit}) ? AccLimit : mul10[31:0];

  assign final_value = negative ? (32'd0 - number_acc)
                                : (number_acc[31] ? PosMax : number_acc);
  assign idle_inc = (idle_ticks == 8'hFF) ? idle_ticks : idle_ticks + 8'd1;
  assign is_term  = (item.rx_byte == ChCr) || (item.rx_byte == ChLf);

  always_comb begin
    armed_next       = armed;
    byte_count_next  = byte_count;
    idle_ticks_next  = idle_ticks;
    xor_sum_next     = xor_sum;
    last_byte_next   = last_byte;
    first_byte_next  = first_byte;
    parse_phase_next = parse_phase;
    negative_next    = negative;
    number_acc_next  = number_acc;
    clear            = 1'b0;
    res.valid        = 1'b0;
    res.rsp.status   = StOk;
    res.rsp.value    = '0;

    if (step) begin
      unique case (item.op)
        OpArm: begin
          armed_next = 1'b1;
          clear      = 1'b1;
        end
        OpTick: begin
          if (armed) begin
            idle_ticks_next = idle_inc;
            if (idle_inc >= timeout_ticks) begin
              res.valid      = 1'b1;
              res.rsp.status = StTimeout;
            end
          end
        end
        OpByte: begin
          if (armed) begin
            idle_ticks_next = '0;
            if (is_term) begin
              res.valid = 1'b1;
              priority if ((byte_count == 5'd0) || (xor_sum != 8'd0)) begin
                res.rsp.status = StChecksum;
              end else if (byte_count == 5'd1) begin
                res.rsp.status = StOk;
              end else if (first_byte == ChO) begin
                res.rsp.status = StOk;
              end else if (first_byte == ChE) begin
                res.rsp.status = StError;
              end else if (first_byte == ChC) begin
                res.rsp.status = StUnknown;
              end else begin
                res.rsp.status = StOk;
                res.rsp.value  = final_value;
              end
            end else begin
              if (byte_count == 5'd0) begin
                first_byte_next = item.rx_byte;
              end else begin
                unique case (parse_phase)
                  PhLead: begin
                    priority if (p_space) begin
                      parse_phase_next = PhLead;
                    end else if (p_sign) begin
                      negative_next    = (last_byte == ChMinus);
                      parse_phase_next = PhNum;
                    end else if (p_digit) begin
                      parse_phase_next = PhNum;
                      number_acc_next  = acc_sat;
                    end else begin
                      parse_phase_next = PhDone;
                    end
                  end
                  PhNum: begin
                    if (p_digit) begin
                      number_acc_next = acc_sat;
                    end else begin
                      parse_phase_next = PhDone;
                    end
                  end
                  default: begin
                    parse_phase_next = parse_phase;
                  end
                endcase
              end
              last_byte_next  = item.rx_byte;
              xor_sum_next    = xor_sum ^ item.rx_byte;
              byte_count_next = byte_count + 5'd1;
              if (byte_count_next >= 5'(MAX_FRAME)) begin
                res.valid      = 1'b1;
                res.rsp.status = StOverflow;
              end
            end
          end
        end
        default: begin
          armed_next = armed;
        end
      endcase
    end

    if (res.valid) begin
      armed_next = 1'b0;
      clear      = 1'b1;
    end
    if (clear) begin
      byte_count_next  = '0;
      idle_ticks_next  = '0;
      xor_sum_next     = '0;
      last_byte_next   = '0;
      first_byte_next  = '0;
      parse_phase_next = PhLead;
      negative_next    = 1'b0;
      number_acc_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed       <= 1'b0;
      byte_count  <= '0;
      idle_ticks  <= '0;
      xor_sum     <= '0;
      last_byte   <= '0;
      first_byte  <= '0;
      parse_phase <= PhLead;
      negative    <= 1'b0;
      number_acc  <= '0;
    end else begin
      armed       <= armed_next;
      byte_count  <= byte_count_next;
      idle_ticks  <= idle_ticks_next;
      xor_sum     <= xor_sum_next;
      last_byte   <= last_byte_next;
      first_byte  <= first_byte_next;
      parse_phase <= parse_phase_next;
      negative    <= negative_next;
      number_acc  <= number_acc_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/reply_frame_receiver.sv
// path: a word is taken into the input register, then the frame logic
// writes its result into the result register
// throughput: one word per cycle while rsp_stall does not hold a result, every op takes one pass
// reset: synchronous active-high rst disarms, clears the frame state and the valid
// flags of both pipeline registers, and sets timeout_ticks to 11
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module reply_frame_receiver
  import rfr_pkg::*;
#(
  parameter int unsigned MAX_FRAME = MaxFrameDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  logic      s1_valid;
  req_t      s1_item;
  logic      out_free;
  logic      advance;
  logic [7:0] timeout_ticks;
  step_res_t res;
  logic      armed;

  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign advance   = s1_valid && out_free;
  assign req_stall = s1_valid && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TimeoutReset;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!req_stall) begin
      s1_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      s1_item <= req;
    end
  end

  rfr_core #(
    .MAX_FRAME(MAX_FRAME)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step         (advance),
    .item         (s1_item),
    .timeout_ticks(timeout_ticks),
    .res          (res),
    .armed        (armed)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_free) begin
      rsp_valid <= advance && res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.valid) begin
      rsp <= res.rsp;
    end
  end

  `RFR_ASSERT_IMP(a_err_value_zero, clk, rst, rsp_valid && (rsp.status != StOk), rsp.value == 32'sd0)
  `RFR_ASSERT_NXT(a_word_held, clk, rst, s1_valid && !out_free, s1_valid && $stable(s1_item))
  `RFR_ASSERT_NXT(a_result_disarms, clk, rst, advance && res.valid, !armed)
  `RFR_ASSERT_NXT(a_cfg_write, clk, rst, cfg_valid && cfg_ready, timeout_ticks == $past(cfg_data))

endmodule

`default_nettype wire

FILE: verif/reply_frame_checker.sv
`timescale 1ns / 1ps

module reply_frame_checker
  import rfr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  input  logic req_stall,
  input  req_t req,
  input  logic rsp_valid,
  input  logic rsp_stall,
  input  rsp_t rsp,
  input  logic cfg_valid,
  input  logic cfg_ready,
  input  logic [7:0] cfg_data,
  output int   errors,
  output int   pending
);

  logic [7:0]  timeout_ticks;
  logic        armed;
  logic [4:0]  byte_count;
  logic [7:0]  idle_ticks;
  logic [7:0]  xor_sum;
  logic [7:0]  last_byte;
  logic [7:0]  first_byte;
  logic [1:0]  parse_phase;
  logic        negative;
  logic [31:0] number_acc;

  rsp_t expected_replies[$];
  rsp_t want;
  rsp_t got;
  bit   fired;

  function void clear_frame();
    byte_count  = '0;
    idle_ticks  = '0;
    xor_sum     = '0;
    last_byte   = '0;
    first_byte  = '0;
    parse_phase = PhLead;
    negative    = 1'b0;
    number_acc  = '0;
  endfunction

  task flag_mismatch(input string what);
    errors++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // the byte before the terminator is the checksum, so parsing runs one byte late
  task automatic decode_word(input req_t w, output bit hit, output rsp_t r);
    logic [7:0]  b;
    logic [7:0]  d;
    logic [63:0] n;
    bit          digit;
    bit          take;
    b = w.rx_byte;
    hit = 1'b0;
    r = '0;
    case (w.op)
      OpArm: begin
        armed = 1'b1;
        clear_frame();
      end
      OpTick: begin
        if (armed) begin
          if (idle_ticks != 8'hFF) idle_ticks = idle_ticks + 8'd1;
          if (idle_ticks >= timeout_ticks) begin
            hit = 1'b1;
            r.status = StTimeout;
          end
        end
      end
      OpByte: begin
        if (armed) begin
          idle_ticks = '0;
          if (b == ChCr || b == ChLf) begin
            hit = 1'b1;
            if (byte_count == 0 || xor_sum != 0) r.status = StChecksum;
            else if (byte_count == 1 || first_byte == ChO) r.status = StOk;
            else if (first_byte == ChE) r.status = StError;
            else if (first_byte == ChC) r.status = StUnknown;
            else begin
              r.status = StOk;
              if (negative) r.value = 32'd0 - number_acc;
              else r.value = (number_acc > PosMax) ? PosMax : number_acc;
            end
          end else begin
            if (byte_count == 0) begin
              first_byte = b;
            end else begin
              d = last_byte;
              digit = (d >= ChZero && d <= ChNine);
              take = 1'b0;
              if (parse_phase == PhLead) begin
                if (d == ChSpace || (d >= ChTab && d <= ChCr)) begin
                end else if (d == ChMinus || d == ChPlus) begin
                  negative = (d == ChMinus);
                  parse_phase = PhNum;
                end else if (digit) begin
                  parse_phase = PhNum;
                  take = 1'b1;
                end else begin
                  parse_phase = PhDone;
                end
              end else if (parse_phase == PhNum) begin
                if (digit) take = 1'b1;
                else parse_phase = PhDone;
              end
              if (take) begin
                n = {32'd0, number_acc} * 64'd10 + {56'd0, d - ChZero};
                if (n > {32'd0, AccLimit}) n = {32'd0, AccLimit};
                number_acc = n[31:0];
              end
            end
            last_byte = b;
            xor_sum = xor_sum ^ b;
            byte_count = byte_count + 5'd1;
            if (byte_count >= MaxFrameDefault) begin
              hit = 1'b1;
              r.status = StOverflow;
            end
          end
        end
      end
      default: begin
      end
    endcase
    if (hit) begin
      armed = 1'b0;
      clear_frame();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timeout_ticks = TimeoutReset;
      armed = 1'b0;
      clear_frame();
      expected_replies.delete();
      pending = 0;
    end else begin
      if (cfg_valid && cfg_ready) timeout_ticks = cfg_data;
      if (rsp_valid && !rsp_stall) begin
        if (expected_replies.size() == 0) begin
          flag_mismatch($sformatf("unexpected word status %0d value %0d",
                                  rsp.status, rsp.value));
        end else begin
          want = expected_replies.pop_front();
          if (rsp.status !== want.status)
            flag_mismatch($sformatf("status %0d, wanted %0d", rsp.status, want.status));
          if (rsp.value !== want.value)
            flag_mismatch($sformatf("value %0d, wanted %0d", rsp.value, want.value));
        end
      end
      if (req_valid && !req_stall) begin
        decode_word(req, fired, got);
        if (fired) expected_replies.push_back(got);
      end
      pending = expected_replies.size();
    end
  end

endmodule

FILE: verif/tb_reply_frame_receiver.sv
`timescale 1ns / 1ps

module tb_reply_frame_receiver;
  import rfr_pkg::*;

  typedef logic [7:0] byte_q [$];

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       req_valid = 1'b0;
  logic       req_stall;
  req_t       req = '0;
  logic       rsp_valid;
  logic       rsp_stall = 1'b0;
  rsp_t       rsp;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [7:0] cfg_data = '0;
  int         errors;
  int         pending;

  bit         idle_on = 1'b1;
  bit         hold_off_now = 1'b0;
  logic [7:0] cur_timeout = TimeoutReset;
  int         words_sent = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  reply_frame_receiver dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  reply_frame_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pause_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == ChCr || b == ChLf) b = ~b;
    return b;
  endfunction

  function automatic byte_q number_body();
    byte_q b;
    int n;
    n = $urandom_range(0, 2);
    repeat (n) begin
      case ($urandom_range(0, 3))
        0: b.push_back(ChSpace);
        1: b.push_back(ChTab);
        2: b.push_back(ChTab + 8'd2);
        default: b.push_back(ChTab + 8'd3);
      endcase
    end
    case ($urandom_range(0, 2))
      0: b.push_back(ChMinus);
      1: b.push_back(ChPlus);
      default: begin
      end
    endcase
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 9);
    repeat (n) b.push_back(ChZero + 8'($urandom_range(0, 9)));
    if ($urandom_range(0, 3) == 0) b.push_back(8'($urandom_range(0, 255)));
    return b;
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      if (hold_off_now) begin
        hold_off_now = 1'b0;
        rsp_stall <= 1'b1;
        for (n = 0; n < 300; n++) @(posedge clk);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        repeat (pause_len()) @(posedge clk);
      end else begin
        rsp_stall <= 1'b0;
        @(posedge clk);
      end
    end
  end

  task automatic send_word(input logic [1:0] code, input logic [7:0] data);
    int gap;
    req_valid <= 1'b1;
    req <= {code, data};
    do @(posedge clk); while (req_stall);
    words_sent++;
    gap = (idle_on && $urandom_range(0, 2) == 0) ? pause_len() : 0;
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_frame(input byte_q body, input logic [7:0] flip, input bit ticks);
    logic [7:0] sum;
    sum = '0;
    send_word(OpArm, 8'($urandom_range(0, 255)));
    foreach (body[i]) begin
      if (ticks && cur_timeout > 1 && $urandom_range(0, 7) == 0)
        send_word(OpTick, 8'($urandom_range(0, 255)));
      send_word(OpByte, body[i]);
      sum = sum ^ body[i];
    end
    send_word(OpByte, sum ^ flip);
    send_word(OpByte, $urandom_range(0, 1) ? ChCr : ChLf);
  endtask

  task automatic drain_replies();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [7:0] v);
    drain_replies();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_timeout = v;
  endtask

  task automatic random_items(input int count);
    int stop;
    int kind;
    int n;
    byte_q body;
    stop = words_sent + count;
    while (words_sent < stop) begin
      kind = $urandom_range(0, 99);
      body = {};
      if (kind < 45) begin
        send_frame(number_body(), 8'd0, 1'b1);
      end else if (kind < 60) begin
        case ($urandom_range(0, 2))
          0: body.push_back(ChO);
          1: body.push_back(ChE);
          default: body.push_back(ChC);
        endcase
        repeat ($urandom_range(0, 5)) body.push_back(plain_byte());
        send_frame(body, 8'd0, 1'b1);
      end else if (kind < 68) begin
        repeat ($urandom_range(0, 18)) body.push_back(8'($urandom_range(0, 255)));
        send_frame(body, 8'd0, 1'b0);
      end else if (kind < 76) begin
        send_word(OpArm, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(19, 22)) send_word(OpByte, plain_byte());
      end else if (kind < 84) begin
        send_word(OpArm, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 3)) send_word(OpByte, ChZero + 8'($urandom_range(0, 9)));
        if (cur_timeout > 40) n = $urandom_range(1, 40);
        else n = (cur_timeout == 0) ? 1 : cur_timeout;
        repeat (n) send_word(OpTick, 8'($urandom_range(0, 255)));
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 6))
          send_word(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else begin
        send_frame(number_body(), 8'($urandom_range(1, 255)), 1'b1);
      end
    end
  endtask

  initial begin
    byte_q body;
    logic [7:0] settings [6];
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // terminator only
    send_word(OpArm, 8'h00);
    send_word(OpByte, ChCr);
    // lone zero byte as checksum
    send_word(OpArm, 8'hFF);
    send_word(OpByte, 8'h00);
    send_word(OpByte, ChLf);
    // re-arm mid frame, then an ok reply
    send_word(OpArm, 8'h00);
    send_word(OpByte, ChZero + 8'd7);
    send_word(OpArm, 8'h00);
    send_word(OpByte, ChO);
    send_word(OpByte, ChO);
    send_word(OpByte, ChCr);
    // disarmed traffic and the unused op
    send_word(OpByte, 8'hFF);
    send_word(OpTick, 8'h00);
    send_word(2'd3, 8'hFF);
    // value beyond the positive limit
    body = {};
    repeat (10) body.push_back(ChNine);
    send_frame(body, 8'd0, 1'b0);

    random_items(90);

    settings = '{8'd255, 8'd0, 8'd1, 8'd3, 8'($urandom_range(2, 254)), TimeoutReset};
    foreach (settings[i]) begin
      write_timeout(settings[i]);
      idle_on = (i % 3 != 1);
      if (settings[i] == 8'd255) begin
        send_word(OpArm, 8'h00);
        repeat (255) send_word(OpTick, 8'($urandom_range(0, 255)));
      end
      random_items(90);
    end

    // long receiver hold-off while the sender keeps pushing short frames
    drain_replies();
    idle_on = 1'b0;
    hold_off_now = 1'b1;
    repeat (30) begin
      send_word(OpArm, 8'($urandom_range(0, 255)));
      send_word(OpByte, ChCr);
    end
    idle_on = 1'b1;
    random_items(50);

    drain_replies();
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
